FILE: hw/rtl/vtdh_pkg.sv
// Shared types, constants and helpers for the vertex triple dedup hash block.
package vtdh_pkg;

  localparam int INDEX_BITS    = 20;
  localparam int REF_BITS      = 21;
  localparam int HASH_BITS     = 12;
  localparam int TABLE_DEPTH   = 1 << HASH_BITS;
  localparam int ELEM_BITS     = 13;
  localparam int OUT_ELEM_BITS = 12;
  localparam int CFG_IDX_BITS  = 2;

  // Multipliers of the bucket hash
  localparam logic [31:0] PRIME_P = 32'd492876863;
  localparam logic [31:0] PRIME_T = 32'd633910099;
  localparam logic [31:0] PRIME_N = 32'd805306457;

  typedef logic [INDEX_BITS-1:0] slot_t;
  typedef logic [HASH_BITS-1:0]  bucket_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POSITION_COUNT = 2'd0,
    CFG_TEXCOORD_COUNT = 2'd1,
    CFG_NORMAL_TOTAL   = 2'd2
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_t;

  // Operand select of the shared multiplier
  typedef enum logic [1:0] {
    LANE_P = 2'd0,
    LANE_T = 2'd1,
    LANE_N = 2'd2
  } lane_t;

  typedef struct packed {
    slot_t pos;
    slot_t tex;
    slot_t nrm;
  } key_t;

  typedef struct packed {
    logic                     valid;
    key_t                     key;
    bucket_t                  home;
    logic [OUT_ELEM_BITS-1:0] element;
  } entry_t;

  typedef struct packed {
    logic  clear;
    logic  step;
    lane_t lane;
  } hash_ctl_t;

  typedef struct packed {
    logic    rd;
    logic    wr;
    bucket_t addr;
    entry_t  wdata;
  } tbl_req_t;

  typedef struct packed {
    logic [OUT_ELEM_BITS-1:0] vertex_index;
    logic                     is_new;
    slot_t                    position_slot;
    slot_t                    texcoord_slot;
    slot_t                    normal_slot;
    logic                     table_full;
  } result_t;

  // 1-based reference to 0-based slot; negative counts back from the end
  function automatic slot_t resolve(input logic [REF_BITS-1:0] r,
                                    input slot_t count);
    slot_t v;
    if (r == '0) begin
      v = '0;
    end else if (r[REF_BITS-1]) begin
      v = count + r[INDEX_BITS-1:0];
    end else begin
      v = r[INDEX_BITS-1:0] - 1'b1;
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/vtdh_corner_if.sv
// Input channel: one face corner with three attribute references.
interface vtdh_corner_if;
  import vtdh_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [REF_BITS-1:0] position_ref;
  logic signed [REF_BITS-1:0] texcoord_ref;
  logic signed [REF_BITS-1:0] normal_ref;

  modport source (output valid, position_ref, texcoord_ref, normal_ref, input ready);
  modport sink   (input valid, position_ref, texcoord_ref, normal_ref, output ready);
endinterface

FILE: hw/rtl/vtdh_result_if.sv
// Output channel: deduplicated element index and resolved slots.
interface vtdh_result_if;
  import vtdh_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OUT_ELEM_BITS-1:0] vertex_index;
  logic                     is_new;
  slot_t                    position_slot;
  slot_t                    texcoord_slot;
  slot_t                    normal_slot;
  logic                     table_full;

  modport source (output valid, vertex_index, is_new, position_slot, texcoord_slot,
                  normal_slot, table_full, input ready);
  modport sink   (input valid, vertex_index, is_new, position_slot, texcoord_slot,
                  normal_slot, table_full, output ready);
endinterface

FILE: hw/rtl/vtdh_cfg_if.sv
// Configuration write channel: register index and write data.
interface vtdh_cfg_if;
  import vtdh_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  slot_t                   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/vertex_triple_dedup_hash.sv
// Vertex triple dedup: one corner in, one element index out, via a probed hash table.
// From accept, the hash steps run, then P buckets are probed (1..4096), then the result is registered.
// A new corner is taken only after the last result is loaded; the single table port serves each probe.
// The hash steps through the three slots on one shared 20x32 multiplier.
// Reset: synchronous; a sweep then clears all 4096 buckets before the first corner.
// Config registers reset to 0; writes are taken at any time.
module vertex_triple_dedup_hash (
  input logic           clk,
  input logic           rst,
  vtdh_corner_if.sink   corner,
  vtdh_result_if.source result,
  vtdh_cfg_if.sink      cfg
);
  import vtdh_pkg::*;

  slot_t     position_count;
  slot_t     texcoord_count;
  slot_t     normal_total;
  key_t      key;
  bucket_t   home;
  entry_t    rdata;
  hash_ctl_t hash_ctl;
  tbl_req_t  tbl_req;
  result_t   out_data;
  logic      in_ready;
  logic      out_valid;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      texcoord_count <= '0;
      normal_total   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_POSITION_COUNT: position_count <= cfg.data;
        CFG_TEXCOORD_COUNT: texcoord_count <= cfg.data;
        CFG_NORMAL_TOTAL:   normal_total   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // resolve references as the word is taken
  always_ff @(posedge clk) begin
    if (corner.valid && in_ready) begin
      key.pos <= resolve(corner.position_ref, position_count);
      key.tex <= resolve(corner.texcoord_ref, texcoord_count);
      key.nrm <= resolve(corner.normal_ref, normal_total);
    end
  end

  assign corner.ready = in_ready;

  vtdh_hash u_hash (
    .clk  (clk),
    .ctl  (hash_ctl),
    .key  (key),
    .home (home)
  );

  vtdh_table u_table (
    .clk   (clk),
    .req   (tbl_req),
    .rdata (rdata)
  );

  vtdh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corner.valid),
    .in_ready  (in_ready),
    .key       (key),
    .home      (home),
    .rdata     (rdata),
    .hash_ctl  (hash_ctl),
    .tbl_req   (tbl_req),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  // result channel
  assign result.valid         = out_valid;
  assign result.vertex_index  = out_data.vertex_index;
  assign result.is_new        = out_data.is_new;
  assign result.position_slot = out_data.position_slot;
  assign result.texcoord_slot = out_data.texcoord_slot;
  assign result.normal_slot   = out_data.normal_slot;
  assign result.table_full    = out_data.table_full;
endmodule

FILE: hw/rtl/vtdh_hash.sv
// Shared multiplier that folds the three slots into the home bucket, one per cycle.
module vtdh_hash (
  input  logic                clk,
  input  vtdh_pkg::hash_ctl_t ctl,
  input  vtdh_pkg::key_t      key,
  output vtdh_pkg::bucket_t   home
);
  import vtdh_pkg::*;

  slot_t       operand;
  logic [31:0] prime;
  logic [31:0] product;
  bucket_t     acc;

  // operand select
  always_comb begin
    case (ctl.lane)
      LANE_P: begin
        operand = key.pos;
        prime   = PRIME_P;
      end
      LANE_T: begin
        operand = key.tex;
        prime   = PRIME_T;
      end
      LANE_N: begin
        operand = key.nrm;
        prime   = PRIME_N;
      end
      default: begin
        operand = '0;
        prime   = '0;
      end
    endcase
  end

  // 32-bit wrapping product; only the low bucket bits survive the mask
  assign product = 32'(operand) * prime;

  // xor accumulator
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.step) begin
      acc <= acc ^ product[HASH_BITS-1:0];
    end
  end

  assign home = acc;
endmodule

FILE: hw/rtl/vtdh_table.sv
// Bucket memory: one port, write or registered read at one address per cycle.
module vtdh_table (
  input  logic               clk,
  input  vtdh_pkg::tbl_req_t req,
  output vtdh_pkg::entry_t   rdata
);
  import vtdh_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end
endmodule

FILE: hw/rtl/vtdh_ctrl.sv
// Sequencer: clearing sweep, hash steps, linear probing and result register.
module vtdh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vtdh_pkg::key_t      key,
  input  vtdh_pkg::bucket_t   home,
  input  vtdh_pkg::entry_t    rdata,
  output vtdh_pkg::hash_ctl_t hash_ctl,
  output vtdh_pkg::tbl_req_t  tbl_req,
  output logic                out_valid,
  input  logic                out_ready,
  output vtdh_pkg::result_t   out_data
);
  import vtdh_pkg::*;

  state_t                state;
  state_t                state_next;
  lane_t                 lane;
  bucket_t               probe_cnt;
  logic [ELEM_BITS-1:0]  next_element;
  result_t               hold;

  bucket_t               probe_addr;
  logic                  match;
  logic                  insert;
  logic                  full;
  logic                  probe_end;
  logic                  out_load;

  // probe compare
  assign probe_addr = home + probe_cnt;
  assign match      = rdata.valid && (rdata.home == home) && (rdata.key == key);
  assign insert     = !rdata.valid;
  assign full       = rdata.valid && !match && (probe_cnt == '1);
  assign probe_end  = insert || match || full;
  assign out_load   = (state == ST_DONE) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (probe_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_HASH;
      ST_HASH:  if (lane == LANE_N) state_next = ST_PROBE;
      ST_PROBE: state_next = ST_CMP;
      ST_CMP:   state_next = probe_end ? ST_DONE : ST_PROBE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs to hash unit and table
  always_comb begin
    in_ready       = 1'b0;
    hash_ctl.clear = 1'b0;
    hash_ctl.step  = 1'b0;
    hash_ctl.lane  = lane;
    tbl_req.rd     = 1'b0;
    tbl_req.wr     = 1'b0;
    tbl_req.addr   = probe_addr;
    tbl_req.wdata  = '0;
    case (state)
      ST_CLEAR: begin
        tbl_req.wr   = 1'b1;
        tbl_req.addr = probe_cnt;
      end
      ST_IDLE: begin
        in_ready       = 1'b1;
        hash_ctl.clear = in_valid;
      end
      ST_HASH: begin
        hash_ctl.step = 1'b1;
      end
      ST_PROBE: begin
        tbl_req.rd = 1'b1;
      end
      ST_CMP: begin
        tbl_req.wr            = insert;
        tbl_req.wdata.valid   = 1'b1;
        tbl_req.wdata.key     = key;
        tbl_req.wdata.home    = home;
        tbl_req.wdata.element = next_element[OUT_ELEM_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      lane         <= LANE_P;
      probe_cnt    <= '0;
      next_element <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: probe_cnt <= probe_cnt + 1'b1;
        ST_IDLE:  lane <= LANE_P;
        ST_HASH: begin
          lane      <= lane_t'(lane + 2'd1);
          probe_cnt <= '0;
        end
        ST_CMP: begin
          if (insert) begin
            next_element <= next_element + 1'b1;
          end
          if (!probe_end) begin
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result words
  always_ff @(posedge clk) begin
    if (state == ST_CMP && probe_end) begin
      hold.vertex_index  <= insert ? next_element[OUT_ELEM_BITS-1:0] :
                            (match ? rdata.element : '0);
      hold.is_new        <= insert;
      hold.position_slot <= key.pos;
      hold.texcoord_slot <= key.tex;
      hold.normal_slot   <= key.nrm;
      hold.table_full    <= full;
    end
    if (out_load) begin
      out_data <= hold;
    end
  end
endmodule
